### rtl/core/hkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HID keyboard report package
// Shared constants for the keyboard report state block: command codes,
// report layout and default table size.
// ----------------------------------------------------------------------------
package hkr_pkg;

  // Default number of key slots in the pressed-key table.
  localparam int SLOT_COUNT = 14;

  // Report layout: every report is sixteen bytes long.
  localparam int REPORT_BYTES = 16;
  localparam int POS_W        = $clog2(REPORT_BYTES);
  localparam int CNT_W        = $clog2(2 * REPORT_BYTES);
  localparam int KEY_OFFSET   = 3;

  localparam logic [7:0] KBD_REPORT_ID   = 8'd1;
  localparam logic [7:0] MEDIA_REPORT_ID = 8'd2;

  // Command codes.
  localparam logic [2:0] CMD_SET_KEY   = 3'd0;
  localparam logic [2:0] CMD_SET_MOD   = 3'd1;
  localparam logic [2:0] CMD_SET_MEDIA = 3'd2;
  localparam logic [2:0] CMD_TOG_MOD   = 3'd3;
  localparam logic [2:0] CMD_TOG_MEDIA = 3'd4;

endpackage
`default_nettype wire

### rtl/core/hkr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address. A read of the entry being written returns
// the old contents.
// ----------------------------------------------------------------------------
module hkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/hid_keyboard_report_state.sv
`timescale 1ns / 1ps
`default_nettype none
// A mask command goes from the idle state that accepts it through the decide state
// to the emit or no-change state, which loads its first output transfer; a key
// command first runs the slot scan, which reads the key table one entry per cycle
// through the single RAM read port, and a drain state. One command at a time: the
// block stays busy until the last byte of its reports or its no-change reply is loaded.
// Reset clears the masks and the per-slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// HID keyboard report state
// Keeps the pressed-key table, the modifier mask and the media mask, applies
// one command at a time and streams the resulting keyboard report (and a
// media report when the media mask changed since it was last sent) one byte
// per output transfer, or one no-change reply when nothing changes.
// ----------------------------------------------------------------------------
module hid_keyboard_report_state #(
  parameter int SLOT_COUNT = hkr_pkg::SLOT_COUNT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Command channel
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] key_code,
  input  wire logic [2:0] bit_index,
  input  wire logic       want_on,
  // Report byte channel
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       flag,
  output      logic       byte_valid,
  output      logic [7:0] report_byte,
  output      logic       last
);

  localparam int SLOT_AW = $clog2(SLOT_COUNT);
  localparam int POS_W   = hkr_pkg::POS_W;
  localparam int CNT_W   = hkr_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_NOCHG,
    ST_EMIT
  } state_t;

  state_t state;

  // Latched command fields.
  logic [2:0] cmd_q;
  logic [7:0] code_q;
  logic [2:0] bit_q;
  logic       on_q;

  // Mask state. The key table itself lives in the RAM below.
  logic [7:0] modifier_mask;
  logic [7:0] media_mask;
  logic [7:0] media_sent;

  // One valid bit per slot: a slot that was never written reads as empty.
  logic [SLOT_COUNT-1:0] slot_vld;
  logic                  rd_vld;

  // Slot scan bookkeeping.
  logic [SLOT_AW-1:0] sidx;
  logic               chk_vld;
  logic [SLOT_AW-1:0] chk_idx;
  logic               match_found;
  logic [SLOT_AW-1:0] match_idx;
  logic               empty_found;
  logic [SLOT_AW-1:0] empty_idx;

  // Emission state.
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             send_media;
  logic             flag_q;
  logic             out_valid_next;

  // RAM ports.
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         cur_slot;

  // Decision results for the current command.
  logic       chg;
  logic       flag_next;
  logic [7:0] bit_mask;
  logic [7:0] modifier_mask_next;
  logic [7:0] media_mask_next;

  // Byte formatting.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             in_second;
  logic             last_byte;
  logic [7:0]       emit_byte;
  logic             out_free;

  hkr_ram #(
    .WIDTH (8),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cur_slot  = rd_vld ? ram_rdata : 8'd0;

  // The output register keeps a stalled transfer and loads a new one whenever
  // the emitting states find it free.
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if ((state == ST_NOCHG || state == ST_EMIT) && out_free) begin
      out_valid_next = 1'b1;
    end
  end

  // The byte counter advances on each loaded output byte. The RAM is
  // addressed with the next counter value so that the slot for the current
  // byte is already on the read port when that byte is formatted.
  always_comb begin
    if (state == ST_DECIDE) begin
      cnt_next = '0;
    end else if (state == ST_EMIT && out_free) begin
      cnt_next = cnt + CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  assign pos       = cnt[POS_W-1:0];
  assign pos_next  = cnt_next[POS_W-1:0];
  assign in_second = cnt[CNT_W-1];

  always_comb begin
    if (state == ST_SCAN) begin
      ram_raddr = sidx;
    end else if (pos_next < POS_W'(hkr_pkg::KEY_OFFSET)) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = SLOT_AW'(pos_next - POS_W'(hkr_pkg::KEY_OFFSET));
    end
  end

  // Apply the latched command to the current state.
  always_comb begin
    bit_mask           = 8'd1 << bit_q;
    chg                = 1'b0;
    flag_next          = 1'b0;
    modifier_mask_next = modifier_mask;
    media_mask_next    = media_mask;
    ram_waddr          = empty_idx;
    ram_wdata          = code_q;
    case (cmd_q)
      hkr_pkg::CMD_SET_KEY: begin
        if (code_q == 8'd0) begin
          chg = 1'b0;
        end else if (on_q) begin
          chg = !match_found && empty_found;
        end else begin
          chg       = match_found;
          ram_waddr = match_idx;
          ram_wdata = 8'd0;
        end
        flag_next = chg;
      end
      hkr_pkg::CMD_SET_MOD: begin
        chg       = ((modifier_mask & bit_mask) != 8'd0) != on_q;
        flag_next = chg;
        modifier_mask_next = on_q ? (modifier_mask | bit_mask)
                                  : (modifier_mask & ~bit_mask);
      end
      hkr_pkg::CMD_SET_MEDIA: begin
        chg       = ((media_mask & bit_mask) != 8'd0) != on_q;
        flag_next = chg;
        media_mask_next = on_q ? (media_mask | bit_mask)
                               : (media_mask & ~bit_mask);
      end
      hkr_pkg::CMD_TOG_MOD: begin
        chg                = 1'b1;
        modifier_mask_next = modifier_mask ^ bit_mask;
        flag_next          = (modifier_mask_next & bit_mask) != 8'd0;
      end
      hkr_pkg::CMD_TOG_MEDIA: begin
        chg             = 1'b1;
        media_mask_next = media_mask ^ bit_mask;
        flag_next       = (media_mask_next & bit_mask) != 8'd0;
      end
      default: begin
        chg = 1'b0;
      end
    endcase
  end

  assign ram_we = (state == ST_DECIDE) && chg && (cmd_q == hkr_pkg::CMD_SET_KEY);

  // Report byte for the current position. Bytes from the key offset on come
  // straight from the slot table; the media report repeats them.
  always_comb begin
    if (pos == POS_W'(0)) begin
      emit_byte = in_second ? hkr_pkg::MEDIA_REPORT_ID : hkr_pkg::KBD_REPORT_ID;
    end else if (pos == POS_W'(1)) begin
      emit_byte = in_second ? media_mask : modifier_mask;
    end else if (pos == POS_W'(2)) begin
      emit_byte = 8'd0;
    end else begin
      emit_byte = cur_slot;
    end
  end

  assign last_byte = (pos == POS_W'(hkr_pkg::REPORT_BYTES - 1)) &&
                     (in_second || !send_media);

  always_ff @(posedge clk) begin
    // Registered read of the valid bit alongside the RAM data.
    rd_vld  <= slot_vld[ram_raddr];
    chk_vld <= !rst && (state == ST_SCAN);
    chk_idx <= sidx;
    cnt     <= cnt_next;

    // First match and first empty slot, checked as scan data returns.
    if (chk_vld) begin
      if (!match_found && cur_slot == code_q) begin
        match_found <= 1'b1;
        match_idx   <= chk_idx;
      end
      if (!empty_found && cur_slot == 8'd0) begin
        empty_found <= 1'b1;
        empty_idx   <= chk_idx;
      end
    end

    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      modifier_mask <= 8'd0;
      media_mask    <= 8'd0;
      media_sent    <= 8'd0;
      slot_vld      <= '0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q       <= cmd;
            code_q      <= key_code;
            bit_q       <= bit_index;
            on_q        <= want_on;
            sidx        <= '0;
            match_found <= 1'b0;
            empty_found <= 1'b0;
            state       <= (cmd == hkr_pkg::CMD_SET_KEY) ? ST_SCAN : ST_DECIDE;
          end
        end
        ST_SCAN: begin
          sidx <= sidx + SLOT_AW'(1);
          if (sidx == SLOT_AW'(SLOT_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          modifier_mask <= modifier_mask_next;
          media_mask    <= media_mask_next;
          flag_q        <= flag_next;
          if (ram_we) begin
            slot_vld[ram_waddr] <= 1'b1;
          end
          if (chg) begin
            send_media <= (media_mask_next != media_sent);
            media_sent <= media_mask_next;
            state      <= ST_EMIT;
          end else begin
            state <= ST_NOCHG;
          end
        end
        ST_NOCHG: begin
          if (out_free) begin
            flag        <= 1'b0;
            byte_valid  <= 1'b0;
            report_byte <= 8'd0;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            flag        <= flag_q;
            byte_valid  <= 1'b1;
            report_byte <= emit_byte;
            last        <= last_byte;
            if (last_byte) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/hkr_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HID keyboard report checker
// Port-level assertions for the keyboard report state block.
// ----------------------------------------------------------------------------
module hkr_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       flag,
  input wire logic       byte_valid,
  input wire logic [7:0] report_byte,
  input wire logic       last
);

  // After reset the block is idle with nothing pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // An accepted command keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command channel open right after a transfer");

  // A non-final report byte means the command is still being worked on.
  a_busy_mid_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("new command taken in the middle of a report");

  // The no-change marker carries nothing else.
  a_nochg_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && !flag && report_byte == 8'd0)
    else $error("malformed no-change transfer");

  // A stalled output transfer holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_byte) &&
                               $stable(last) && $stable(flag) && $stable(byte_valid))
    else $error("stalled output changed");

endmodule

bind hid_keyboard_report_state hkr_check u_hkr_check (.*);
`default_nettype wire

### tb/hid_keyboard_report_state_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID keyboard report state checker
// Watches both channels of the report block, keeps its own copy of the key
// table and the masks, predicts the report bytes of every command and
// compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module hid_keyboard_report_state_check #(
  parameter int SLOT_COUNT = hkr_pkg::SLOT_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] key_code,
  input  logic [2:0] bit_index,
  input  logic       want_on,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       flag,
  input  logic       byte_valid,
  input  logic [7:0] report_byte,
  input  logic       last,
  output int         errors,
  output int         pending,
  output int         beats_checked,
  output int         idle_replies
);
  import hkr_pkg::*;

  typedef struct packed {
    logic       flag;
    logic       byte_valid;
    logic [7:0] data;
    logic       last;
  } report_beat_t;

  report_beat_t expected_beats[$];
  logic [7:0]   held_keys [SLOT_COUNT];
  logic [7:0]   modifier_bits;
  logic [7:0]   media_bits;
  logic [7:0]   media_reported;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Press or release one key code; returns whether the table changed.
  function automatic logic apply_key(input logic [7:0] code, input logic on);
    int i;
    if (code == 8'h00) return 1'b0;
    if (on) begin
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (held_keys[i] == code) return 1'b0;
      end
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (held_keys[i] == 8'h00) begin
          held_keys[i] = code;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (held_keys[i] == code) begin
        held_keys[i] = 8'h00;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Queue the keyboard report and, when the media mask moved, the media report.
  task automatic queue_reports(input logic changed_flag);
    logic [7:0]   frame [REPORT_BYTES];
    logic         media_due;
    report_beat_t beat;
    int           i;
    media_due = (media_bits != media_reported);
    frame[0] = KBD_REPORT_ID;
    frame[1] = modifier_bits;
    frame[2] = 8'h00;
    for (i = KEY_OFFSET; i < REPORT_BYTES; i++) begin
      frame[i] = (i - KEY_OFFSET < SLOT_COUNT) ? held_keys[i - KEY_OFFSET] : 8'h00;
    end
    for (i = 0; i < REPORT_BYTES; i++) begin
      beat.flag       = changed_flag;
      beat.byte_valid = 1'b1;
      beat.data       = frame[i];
      beat.last       = !media_due && (i == REPORT_BYTES - 1);
      expected_beats.push_back(beat);
    end
    if (media_due) begin
      frame[0] = MEDIA_REPORT_ID;
      frame[1] = media_bits;
      for (i = 0; i < REPORT_BYTES; i++) begin
        beat.flag       = changed_flag;
        beat.byte_valid = 1'b1;
        beat.data       = frame[i];
        beat.last       = (i == REPORT_BYTES - 1);
        expected_beats.push_back(beat);
      end
      media_reported = media_bits;
    end
  endtask

  task automatic predict_command(input logic [2:0] op, input logic [7:0] code,
                                 input logic [2:0] pos, input logic on);
    logic         changed;
    logic         changed_flag;
    logic [7:0]   bit_mask;
    report_beat_t beat;
    bit_mask     = 8'h01 << pos;
    changed      = 1'b0;
    changed_flag = 1'b0;
    case (op)
      CMD_SET_KEY: begin
        changed      = apply_key(code, on);
        changed_flag = changed;
      end
      CMD_SET_MOD: begin
        changed = (((modifier_bits & bit_mask) != 8'h00) != on);
        if (changed) modifier_bits = modifier_bits ^ bit_mask;
        changed_flag = changed;
      end
      CMD_SET_MEDIA: begin
        changed = (((media_bits & bit_mask) != 8'h00) != on);
        if (changed) media_bits = media_bits ^ bit_mask;
        changed_flag = changed;
      end
      CMD_TOG_MOD: begin
        modifier_bits = modifier_bits ^ bit_mask;
        changed_flag  = |(modifier_bits & bit_mask);
        changed       = 1'b1;
      end
      CMD_TOG_MEDIA: begin
        media_bits   = media_bits ^ bit_mask;
        changed_flag = |(media_bits & bit_mask);
        changed      = 1'b1;
      end
      default: begin
        changed = 1'b0;
      end
    endcase
    if (changed) begin
      queue_reports(changed_flag);
    end else begin
      beat.flag       = 1'b0;
      beat.byte_valid = 1'b0;
      beat.data       = 8'h00;
      beat.last       = 1'b1;
      expected_beats.push_back(beat);
    end
  endtask

  task automatic check_transfer();
    report_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer flag %0b valid %0b byte %02h last %0b",
                                flag, byte_valid, report_byte, last));
      return;
    end
    want = expected_beats.pop_front();
    beats_checked++;
    if (!want.byte_valid) idle_replies++;
    if ({flag, byte_valid, report_byte, last} !== want) begin
      report_mismatch($sformatf(
        "got flag %0b valid %0b byte %02h last %0b, wanted %0b %0b %02h %0b",
        flag, byte_valid, report_byte, last,
        want.flag, want.byte_valid, want.data, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) held_keys[i] = 8'h00;
      modifier_bits  = 8'h00;
      media_bits     = 8'h00;
      media_reported = 8'h00;
      expected_beats.delete();
      errors         = 0;
      beats_checked  = 0;
      idle_replies   = 0;
    end else begin
      if (in_valid && !in_stall) predict_command(cmd, key_code, bit_index, want_on);
      if (out_valid && !out_stall) check_transfer();
    end
    pending <= expected_beats.size();
  end

endmodule

### tb/hid_keyboard_report_state_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID keyboard report state testbench
// Drives directed and random commands into the report block under three
// mixes of sender gaps and receiver stalls, and lets the checker beside the
// block predict and compare every report byte before giving the verdict.
// ----------------------------------------------------------------------------
module hid_keyboard_report_state_test;
  import hkr_pkg::*;

  localparam int SLOT_COUNT      = hkr_pkg::SLOT_COUNT;
  // Roughly 230 commands in all, directed ones included.
  localparam int RANDOM_COMMANDS = 204;
  // Key codes mostly come from a small pool, so presses and releases meet
  // and the table keeps running into its full state.
  localparam int KEY_POOL        = 20;
  // Longest stretch without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT     = 5000;
  // Quiet time after the last expected byte, to catch stray transfers.
  localparam int DRAIN_CYCLES    = 4 * (SLOT_COUNT + 4);
  // Commands 5 to 7 are undefined and must be answered as no change.
  localparam logic [2:0] CMD_TOP = 3'b111;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] cmd;
  logic [7:0] key_code;
  logic [2:0] bit_index;
  logic       want_on;
  logic       out_valid;
  logic       out_stall;
  logic       flag;
  logic       byte_valid;
  logic [7:0] report_byte;
  logic       last;

  int check_errors;
  int check_pending;
  int beats_checked;
  int idle_replies;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct;
  int stall_pct;
  int sent_count;
  int directed_count;
  int quiet_cycles;

  hid_keyboard_report_state #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .key_code   (key_code),
    .bit_index  (bit_index),
    .want_on    (want_on),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .flag       (flag),
    .byte_valid (byte_valid),
    .report_byte(report_byte),
    .last       (last)
  );

  hid_keyboard_report_state_check #(
    .SLOT_COUNT(SLOT_COUNT)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .key_code     (key_code),
    .bit_index    (bit_index),
    .want_on      (want_on),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .flag         (flag),
    .byte_valid   (byte_valid),
    .report_byte  (report_byte),
    .last         (last),
    .errors       (check_errors),
    .pending      (check_pending),
    .beats_checked(beats_checked),
    .idle_replies (idle_replies)
  );

  always #10 clk = ~clk;

  // The receiver stalls at random; the current mix decides how often.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d bytes still expected",
               QUIET_LIMIT, check_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one command and return at the clock edge where it is transferred.
  // The caller is always right at a rising edge, and this task makes at most
  // one assignment to in_valid per edge, so a back-to-back command keeps
  // valid high without a glitch.
  task automatic send_command(input logic [2:0] op, input logic [7:0] code,
                              input logic [2:0] pos, input logic on);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    key_code  <= code;
    bit_index <= pos;
    want_on   <= on;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    int         n;
    int         pick;
    logic [2:0] op;
    logic [7:0] code;
    logic [2:0] pos;
    logic       on;

    // Every input is known from time zero.
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_SET_KEY;
    key_code      = 8'h00;
    bit_index     = 3'd0;
    want_on       = 1'b0;
    out_stall     = 1'b0;
    quiet_cycles  = 0;
    sent_count    = 0;
    send_idle_pct = 19;
    stall_pct     = 74;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed commands. Code zero marks an empty slot, so pressing it must
    // change nothing and produce a single no-change reply.
    send_command(CMD_SET_KEY, 8'h00, 3'd0, 1'b1);
    // All-ones key code goes into the first slot; pressing it twice is refused.
    send_command(CMD_SET_KEY, 8'hFF, 3'd7, 1'b1);
    send_command(CMD_SET_KEY, 8'hFF, 3'd0, 1'b1);
    // Release it, then release it again when no slot matches any more.
    send_command(CMD_SET_KEY, 8'hFF, 3'd7, 1'b0);
    send_command(CMD_SET_KEY, 8'hFF, 3'd0, 1'b0);
    // Lowest and highest modifier bits, then the top media bit, which also
    // brings out the second report.
    send_command(CMD_SET_MOD, 8'hFF, 3'd0, 1'b1);
    send_command(CMD_SET_MOD, 8'h00, 3'd7, 1'b1);
    send_command(CMD_SET_MEDIA, 8'h00, 3'd7, 1'b1);
    // Toggles report the new bit value: this one clears, the next one sets.
    send_command(CMD_TOG_MOD, 8'h00, 3'd7, 1'b0);
    send_command(CMD_TOG_MEDIA, 8'h00, 3'd0, 1'b1);
    // An undefined command is answered as no change.
    send_command(CMD_TOP, 8'hAA, 3'd5, 1'b1);
    // Fill every slot with distinct codes; the slots past twelve hold keys
    // that never show in a report.
    for (n = 1; n <= SLOT_COUNT; n++) begin
      code = 8'(n * 17);
      send_command(CMD_SET_KEY, code, 3'(n), 1'b1);
    end
    // A new key with the table full changes nothing.
    send_command(CMD_SET_KEY, 8'h7F, 3'd2, 1'b1);
    directed_count = sent_count;

    // Random commands in three mixes: slow receiver, slow sender, then
    // transfers as fast as the block allows.
    for (n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n == RANDOM_COMMANDS / 3) begin
        send_idle_pct = 74;
        stall_pct     = 19;
      end
      if (n == 2 * RANDOM_COMMANDS / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      pick = $urandom_range(99);
      op   = CMD_SET_KEY;
      code = 8'($urandom_range(255));
      pos  = 3'($urandom_range(7));
      on   = 1'($urandom_range(1));
      if (pick < 65) begin
        // Presses outnumber releases so the table tends to fill up.
        on = (pick < 40);
        if ($urandom_range(99) < 85) code = 8'($urandom_range(KEY_POOL, 1));
      end else if (pick < 77) begin
        op = $urandom_range(1) ? CMD_SET_MOD : CMD_SET_MEDIA;
      end else if (pick < 94) begin
        op = $urandom_range(1) ? CMD_TOG_MOD : CMD_TOG_MEDIA;
      end else begin
        op = 3'($urandom_range(CMD_TOP, CMD_TOG_MEDIA + 1));
      end
      send_command(op, code, pos, on);
    end

    // Drop valid, let the checker see the last transfer, then wait for the
    // last report byte and a quiet stretch after it.
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d directed) under slow-receiver, slow-sender and",
             sent_count, directed_count);
    $display("full-rate mixes; %0d result transfers checked, %0d no-change replies.",
             beats_checked, idle_replies);
    if (check_errors == 0 && check_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/hkr_pkg.sv
rtl/core/hkr_ram.sv
rtl/core/hid_keyboard_report_state.sv
rtl/core/hkr_check.sv
tb/hid_keyboard_report_state_check.sv
tb/hid_keyboard_report_state_test.sv
